// ----- rtl/core/mlbs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the multi-channel LED blink sequencer.
// No dependencies; every other file in rtl/core except mlbs_elapse_unit imports this package.
package mlbs_pkg;

    localparam int MLBS_NUM_LEDS_DEF = 4;
    localparam int MLBS_MAX_LEDS     = 16;
    localparam int MLBS_MAX_RES      = 8;
    localparam int MLBS_RES_CNT_W    = 4;
    localparam int MLBS_CH_W         = 4;
    localparam int MLBS_IN_W         = 88;
    localparam int MLBS_OUT_W        = 8;
    localparam int MLBS_ADDR_W       = 3;

    // register indexes
    localparam logic REG_ENABLE = 1'b0;

    typedef enum logic [1:0] {
        OP_SERVICE = 2'd0,
        OP_START   = 2'd1,
        OP_STOP    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        EV_IDLE = 2'd0,
        EV_ON   = 2'd1,
        EV_OFF  = 2'd2,
        EV_DONE = 2'd3
    } ev_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT,
        ST_FINISH
    } seq_state_t;

    // sequencer to output stage
    typedef struct packed {
        logic                 push;
        logic                 fin;
        logic [MLBS_CH_W-1:0] ch;
        ev_t                  ev;
    } out_req_t;

    // output stage to sequencer
    typedef struct packed {
        logic push_ready;
        logic fin_ready;
    } out_ack_t;

endpackage

// ----- rtl/core/multi_led_blink_sequencer.sv -----
`timescale 1ns / 1ps
// Multi-channel LED blink sequencer, top level: sequencer, channel state,
// config register. Depends on mlbs_pkg, mlbs_elapse_unit, mlbs_out_stage.

// The block takes one item at a time and drops s_tready until the item's
// last result has been loaded into the output register. A start item is
// closed at once, and a stop item for a valid channel reports that channel
// off before it closes. A service item with enable set visits the channels
// one by one: it evaluates a channel, reports its events, then advances,
// and it closes the item after the last channel. The sequencer walks the
// single elapsed-time subtract/compare unit across all channels. Each item
// ends with one result flagged tlast; an item with nothing to report gives
// a single idle result on channel 0. At most eight results are given per
// item; further events are dropped, which can only happen with more than
// four channels. The enable register sits at byte address 0 and must be
// written only while the block is idle.
module multi_led_blink_sequencer #(
    parameter int NUM_LEDS = mlbs_pkg::MLBS_NUM_LEDS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream: [1:0] op, [9:2] led, [17:10] count, [33:18] on_time,
    // [49:34] off_time, [81:50] now, [87:82] zero
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mlbs_pkg::MLBS_IN_W-1:0]       s_tdata,
    // output stream: [3:0] channel, [5:4] event_res, [7:6] zero; tlast = last
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mlbs_pkg::MLBS_OUT_W-1:0]      m_tdata,
    output logic                                 m_tlast,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mlbs_pkg::MLBS_ADDR_W-1:0]     paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import mlbs_pkg::*;

    localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_LEDS - 1);

    // input fields
    logic [1:0]  in_op;
    logic [7:0]  in_led;
    logic [7:0]  in_count;
    logic [15:0] in_on_time;
    logic [15:0] in_off_time;
    logic [31:0] in_now;

    assign in_op       = s_tdata[1:0];
    assign in_led      = s_tdata[9:2];
    assign in_count    = s_tdata[17:10];
    assign in_on_time  = s_tdata[33:18];
    assign in_off_time = s_tdata[49:34];
    assign in_now      = s_tdata[81:50];

    // control state
    seq_state_t              state_reg;
    seq_state_t              state_next;
    logic [IDX_W-1:0]        idx_reg;
    logic                    svc_reg;
    logic                    slot_a_valid_reg;
    logic                    slot_b_valid_reg;
    logic [MLBS_RES_CNT_W-1:0] n_reg;
    logic                    enable_reg;

    // per-channel flags
    logic [NUM_LEDS-1:0]     active_reg;
    logic [NUM_LEDS-1:0]     busy_reg;
    logic [NUM_LEDS-1:0]     phase_on_reg;
    logic [NUM_LEDS-1:0]     rep_reg;
    logic [NUM_LEDS-1:0]     taken_reg;

    // per-channel payload
    logic [7:0]              cycles_reg [NUM_LEDS];
    logic [15:0]             on_dur_reg [NUM_LEDS];
    logic [15:0]             off_dur_reg [NUM_LEDS];
    logic [31:0]             pstart_reg [NUM_LEDS];

    // item payload
    logic [31:0]             now_reg;
    logic [MLBS_CH_W-1:0]    ch_reg;
    ev_t                     slot_a_ev_reg;

    out_req_t                req;
    out_ack_t                ack;

    logic                    accept;
    logic                    led_ok;
    logic [IDX_W-1:0]        led_idx;
    logic                    start_ok;
    logic                    stop_ok;
    logic                    cur_act;
    logic                    cur_ph;
    logic                    cur_taken;
    logic [15:0]             cur_dur;
    logic                    expired;
    logic                    toggle;
    logic [7:0]              cl_new;
    logic                    slot_any;
    logic                    room;
    logic                    emit_adv;
    logic                    cfg_wr;

    assign accept   = s_tvalid && s_tready;
    assign led_ok   = (in_led < 8'(NUM_LEDS));
    assign led_idx  = in_led[IDX_W-1:0];
    assign start_ok = led_ok && !busy_reg[led_idx];
    assign stop_ok  = led_ok;

    // channel under evaluation
    assign cur_act   = active_reg[idx_reg];
    assign cur_ph    = phase_on_reg[idx_reg];
    assign cur_taken = taken_reg[idx_reg];
    assign cur_dur   = cur_ph ? on_dur_reg[idx_reg] : off_dur_reg[idx_reg];

    mlbs_elapse_unit u_elapse (
        .now     (now_reg),
        .start   (pstart_reg[idx_reg]),
        .dur     (cur_dur),
        .expired (expired)
    );

    // the first visit only records the time; later visits may toggle
    assign toggle = cur_taken && expired;
    assign cl_new = (toggle && !cur_ph) ? (cycles_reg[idx_reg] - 8'd1) : cycles_reg[idx_reg];

    assign slot_any = slot_a_valid_reg || slot_b_valid_reg;
    assign room     = (n_reg < MLBS_RES_CNT_W'(MLBS_MAX_RES));
    // past the result limit an event is dropped but still consumed
    assign emit_adv = (state_reg == ST_EMIT) && slot_any && (!room || ack.push_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_SERVICE: state_next = enable_reg ? ST_EVAL : ST_FINISH;
                        OP_STOP:    state_next = stop_ok ? ST_EMIT : ST_FINISH;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_EVAL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!slot_any)
                begin
                    state_next = (svc_reg && (idx_reg != IDX_LAST)) ? ST_EVAL : ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (ack.fin_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        req.push = (state_reg == ST_EMIT) && slot_any && room;
        req.fin  = (state_reg == ST_FINISH);
        req.ch   = ch_reg;
        req.ev   = slot_a_valid_reg ? slot_a_ev_reg : EV_DONE;
    end

    mlbs_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .ack      (ack),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // control registers and per-channel flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            svc_reg          <= 1'b0;
            slot_a_valid_reg <= 1'b0;
            slot_b_valid_reg <= 1'b0;
            n_reg            <= '0;
            active_reg       <= '0;
            busy_reg         <= '0;
            phase_on_reg     <= '0;
            rep_reg          <= '0;
            taken_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        n_reg   <= '0;
                        idx_reg <= '0;
                        svc_reg <= (in_op == OP_SERVICE);
                        if (in_op == OP_START && start_ok)
                        begin
                            active_reg[led_idx]   <= 1'b1;
                            busy_reg[led_idx]     <= 1'b1;
                            phase_on_reg[led_idx] <= 1'b1;
                            rep_reg[led_idx]      <= 1'b0;
                            taken_reg[led_idx]    <= 1'b0;
                        end
                        else if (in_op == OP_STOP && stop_ok)
                        begin
                            // clear the channel and report it off
                            active_reg[led_idx]   <= 1'b0;
                            busy_reg[led_idx]     <= 1'b0;
                            phase_on_reg[led_idx] <= 1'b0;
                            rep_reg[led_idx]      <= 1'b0;
                            taken_reg[led_idx]    <= 1'b0;
                            slot_a_valid_reg      <= 1'b1;
                        end
                    end
                end
                ST_EVAL:
                begin
                    if (cur_act)
                    begin
                        if (!cur_taken)
                        begin
                            taken_reg[idx_reg] <= 1'b1;
                        end
                        else
                        begin
                            if (cur_ph != rep_reg[idx_reg])
                            begin
                                rep_reg[idx_reg] <= cur_ph;
                                slot_a_valid_reg <= 1'b1;
                            end
                            if (expired)
                            begin
                                phase_on_reg[idx_reg] <= !cur_ph;
                            end
                        end
                        if (cl_new == 8'd0)
                        begin
                            active_reg[idx_reg] <= 1'b0;
                            busy_reg[idx_reg]   <= 1'b0;
                            slot_b_valid_reg    <= 1'b1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (emit_adv)
                    begin
                        if (slot_a_valid_reg)
                        begin
                            slot_a_valid_reg <= 1'b0;
                        end
                        else
                        begin
                            slot_b_valid_reg <= 1'b0;
                        end
                        if (room)
                        begin
                            n_reg <= n_reg + MLBS_RES_CNT_W'(1);
                        end
                    end
                    else if (!slot_any && svc_reg && (idx_reg != IDX_LAST))
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_FINISH:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= in_now;
            if (in_op == OP_START && start_ok)
            begin
                cycles_reg[led_idx]  <= in_count;
                on_dur_reg[led_idx]  <= in_on_time;
                off_dur_reg[led_idx] <= in_off_time;
            end
            if (in_op == OP_STOP)
            begin
                ch_reg        <= in_led[MLBS_CH_W-1:0];
                slot_a_ev_reg <= EV_OFF;
            end
        end
        else if (state_reg == ST_EVAL)
        begin
            ch_reg        <= MLBS_CH_W'(idx_reg);
            slot_a_ev_reg <= cur_ph ? EV_ON : EV_OFF;
            if (cur_act)
            begin
                if (!cur_taken || expired)
                begin
                    pstart_reg[idx_reg] <= now_reg;
                end
                cycles_reg[idx_reg] <= cl_new;
            end
        end
    end

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_wr && (paddr[2] == REG_ENABLE))
        begin
            enable_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_ENABLE) ? {31'd0, enable_reg} : 32'd0;

endmodule

// ----- rtl/core/mlbs_elapse_unit.sv -----
`timescale 1ns / 1ps
// Shared elapsed-time unit: wrapping 32-bit subtract and compare against a duration.
// Pure combinational logic; no package dependencies.
module mlbs_elapse_unit (
    input  logic [31:0] now,
    input  logic [31:0] start,
    input  logic [15:0] dur,
    output logic        expired
);

    logic [31:0] elapsed;

    assign elapsed = now - start;
    assign expired = (elapsed >= {16'd0, dur});

endmodule

// ----- rtl/core/mlbs_out_stage.sv -----
`timescale 1ns / 1ps
// Output stage: one held result plus the output register, so the final flag
// can be set once the item ends. Depends on mlbs_pkg.
module mlbs_out_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mlbs_pkg::out_req_t          req,
    output mlbs_pkg::out_ack_t          ack,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mlbs_pkg::MLBS_OUT_W-1:0] m_tdata,   // [3:0] channel, [5:4] event_res
    output logic                        m_tlast    // last
);
    import mlbs_pkg::*;

    logic                 hold_valid_reg;
    logic [MLBS_CH_W-1:0] hold_ch_reg;
    ev_t                  hold_ev_reg;
    logic                 out_valid_reg;
    logic [MLBS_CH_W-1:0] out_ch_reg;
    ev_t                  out_ev_reg;
    logic                 out_last_reg;
    logic                 out_free;
    logic                 do_push;
    logic                 do_fin;

    assign out_free       = !out_valid_reg || m_tready;
    assign ack.push_ready = !hold_valid_reg || out_free;
    assign ack.fin_ready  = out_free;
    assign do_push        = req.push && ack.push_ready;
    assign do_fin         = req.fin && ack.fin_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                hold_valid_reg <= 1'b1;
                if (hold_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                else if (m_tready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (do_fin)
            begin
                hold_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            hold_ch_reg <= req.ch;
            hold_ev_reg <= req.ev;
            if (hold_valid_reg)
            begin
                out_ch_reg   <= hold_ch_reg;
                out_ev_reg   <= hold_ev_reg;
                out_last_reg <= 1'b0;
            end
        end
        else if (do_fin)
        begin
            // an item with nothing to report answers idle on channel 0
            out_ch_reg   <= hold_valid_reg ? hold_ch_reg : '0;
            out_ev_reg   <= hold_valid_reg ? hold_ev_reg : EV_IDLE;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_ev_reg, out_ch_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/core/mlbs_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the blink sequencer, bound to the top level.
// Depends on mlbs_pkg and multi_led_blink_sequencer.
module mlbs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mlbs_pkg::MLBS_OUT_W-1:0]   m_tdata,
    input logic                              m_tlast
);
    import mlbs_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // drop ready once a transaction is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after input transaction");

    // idle result closes an item and names channel 0
    a_idle_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[5:4] == EV_IDLE) |-> m_tlast && (m_tdata[3:0] == 4'd0))
        else $error("malformed idle result");

    // while ready, only the final result of the previous item may wait
    a_ready_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && m_tvalid |-> m_tlast)
        else $error("ready with a non-final result pending");

endmodule

bind multi_led_blink_sequencer mlbs_checker u_mlbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
